FILE: hw/rtl/bfcc_pkg.sv
`timescale 1ns / 1ps

package bfcc_pkg;

  localparam int ID_W      = 11;
  localparam int LEN_W     = 4;
  localparam int PAYLOAD_W = 64;
  localparam int WORD_W    = 16;
  localparam int TIMER_W   = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CRC_BYTES = 6;
  localparam int CRC_DATA_W = 8 * CRC_BYTES;

  localparam logic [WORD_W-1:0]  CRC_INIT    = 16'hFFFF;
  localparam logic [WORD_W-1:0]  CRC_POLY    = 16'hA001;
  localparam logic [LEN_W-1:0]   FRAME_BYTES = 4'd8;
  localparam logic [ID_W-1:0]    TARGET_ID_RESET   = 11'h100;
  localparam logic [WORD_W-1:0]  RETRY_TICKS_RESET = 16'd2000;
  localparam logic [TIMER_W-1:0] TIMER_MAX   = 17'h1FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ID   = 1'b0,
    CFG_RETRY_TICKS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic                 kind;
    logic [ID_W-1:0]      frame_id;
    logic [LEN_W-1:0]     frame_length;
    logic [PAYLOAD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic                     request_send;
    logic                     frame_matched;
    logic                     crc_ok;
    logic [WORD_W-1:0]        computed_crc;
    logic [WORD_W-1:0]        voltage_raw;
    logic signed [WORD_W-1:0] current_raw;
    logic [WORD_W-1:0]        capacity_raw;
  } out_item_t;

  // Control passed from the frame decoder to the retry timer.
  typedef struct packed {
    logic step;
    logic tick;
    logic matched;
  } timer_ctl_t;

  // Bitwise Modbus CRC over six bytes, byte 0 in the top bits. Only used on
  // constants to build the linear form below.
  function automatic logic [WORD_W-1:0] crc_serial(input logic [CRC_DATA_W-1:0] d,
                                                   input logic [WORD_W-1:0] init);
    logic [WORD_W-1:0] c;
    c = init;
    for (int i = 0; i < CRC_BYTES; i++) begin
      c = c ^ {8'h00, d[CRC_DATA_W-1-8*i -: 8]};
      for (int b = 0; b < 8; b++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
    end
    return c;
  endfunction

  // The CRC is linear in the data, so each data bit contributes a fixed
  // column that is XORed onto the CRC of an all-zero message.
  function automatic logic [CRC_DATA_W-1:0][WORD_W-1:0] crc_columns();
    logic [CRC_DATA_W-1:0][WORD_W-1:0] cols;
    for (int k = 0; k < CRC_DATA_W; k++) begin
      cols[k] = crc_serial(CRC_DATA_W'(1) << k, '0);
    end
    return cols;
  endfunction

  localparam logic [WORD_W-1:0] CRC_BASE = crc_serial('0, CRC_INIT);
  localparam logic [CRC_DATA_W-1:0][WORD_W-1:0] CRC_COL = crc_columns();

endpackage

FILE: hw/rtl/bfcc_in_if.sv
`timescale 1ns / 1ps

interface bfcc_in_if import bfcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ID_W-1:0]      frame_id;
  logic [LEN_W-1:0]     frame_length;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, kind, frame_id, frame_length, payload, input ready);
  modport sink   (input valid, kind, frame_id, frame_length, payload, output ready);
endinterface

FILE: hw/rtl/bfcc_out_if.sv
`timescale 1ns / 1ps

interface bfcc_out_if import bfcc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     request_send;
  logic                     frame_matched;
  logic                     crc_ok;
  logic [WORD_W-1:0]        computed_crc;
  logic [WORD_W-1:0]        voltage_raw;
  logic signed [WORD_W-1:0] current_raw;
  logic [WORD_W-1:0]        capacity_raw;

  modport source (output valid, request_send, frame_matched, crc_ok, computed_crc,
                  voltage_raw, current_raw, capacity_raw, input ready);
  modport sink   (input valid, request_send, frame_matched, crc_ok, computed_crc,
                  voltage_raw, current_raw, capacity_raw, output ready);
endinterface

FILE: hw/rtl/bfcc_frame.sv
`timescale 1ns / 1ps

module bfcc_frame import bfcc_pkg::*; (
  input  logic            step,
  input  in_item_t        item,
  input  logic [ID_W-1:0] target_id,
  output timer_ctl_t      ctl,
  output out_item_t       result
);

  logic                  matched;
  logic [CRC_DATA_W-1:0] crc_data;
  logic [WORD_W-1:0]     crc;
  logic [WORD_W-1:0]     carried;

  assign matched  = !item.kind && (item.frame_id == target_id) &&
                    (item.frame_length == FRAME_BYTES);
  assign crc_data = item.payload[PAYLOAD_W-1 -: CRC_DATA_W];
  assign carried  = item.payload[WORD_W-1:0];

  always_comb begin
    crc = CRC_BASE;
    for (int k = 0; k < CRC_DATA_W; k++) begin
      if (crc_data[k]) begin
        crc = crc ^ CRC_COL[k];
      end
    end
  end

  assign ctl.step    = step;
  assign ctl.tick    = item.kind;
  assign ctl.matched = matched;

  always_comb begin
    result = '0;
    if (matched) begin
      result.frame_matched = 1'b1;
      result.crc_ok        = (crc == carried);
      result.computed_crc  = crc;
      result.voltage_raw   = item.payload[63:48];
      result.current_raw   = item.payload[47:32];
      result.capacity_raw  = item.payload[31:16];
    end
  end

endmodule

FILE: hw/rtl/bfcc_timer.sv
`timescale 1ns / 1ps

module bfcc_timer import bfcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  timer_ctl_t        ctl,
  input  logic [WORD_W-1:0] retry_ticks,
  output logic              request
);

  logic [TIMER_W-1:0] elapsed;
  logic [TIMER_W-1:0] elapsed_next;
  logic [TIMER_W-1:0] incremented;

  assign incremented = (elapsed != TIMER_MAX) ? elapsed + TIMER_W'(1) : elapsed;
  assign request     = ctl.step && ctl.tick && (incremented > {1'b0, retry_ticks});

  always_comb begin
    elapsed_next = elapsed;
    if (ctl.step) begin
      if (ctl.tick) begin
        elapsed_next = request ? '0 : incremented;
      end else if (ctl.matched) begin
        elapsed_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else begin
      elapsed <= elapsed_next;
    end
  end

  // The count clears as soon as it passes the limit, so it never gets beyond
  // one more than the largest limit.
  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    elapsed <= TIMER_W'(17'h10000))
    else $error("retry timer ran past its limit");

  a_request_clears: assert property (@(posedge clk) disable iff (rst)
    request |=> (elapsed == '0))
    else $error("retry timer not cleared after a request");

endmodule

FILE: hw/rtl/bms_frame_crc_checker.sv
`timescale 1ns / 1ps
// A request lands in the input register at the edge that accepts it; it is loaded into
// the result register when that register is empty or being taken, else it waits there.
// Throughput: one request per cycle while res.ready is high; CRC is a single XOR network.
// Reset clears both valid flags and the retry timer, and loads target_id with
// 0x100 and retry_ticks with 2000.

module bms_frame_crc_checker import bfcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bfcc_in_if.sink               rx,
  bfcc_out_if.source            res
);

  logic [ID_W-1:0]   target_id;
  logic [WORD_W-1:0] retry_ticks;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_valid;
  out_item_t out_item;

  logic       advance;
  timer_ctl_t ctl;
  out_item_t  frame_result;
  out_item_t  step_result;
  logic       request;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_id   <= TARGET_ID_RESET;
      retry_ticks <= RETRY_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_TARGET_ID:   target_id   <= cfg_data[ID_W-1:0];
        CFG_RETRY_TICKS: retry_ticks <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // The result register loads from a full input register when it is empty or being taken.
  assign advance  = s1_valid && (!out_valid || res.ready);
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_item.kind         <= rx.kind;
      s1_item.frame_id     <= rx.frame_id;
      s1_item.frame_length <= rx.frame_length;
      s1_item.payload      <= rx.payload;
    end
  end

  bfcc_frame u_frame (
    .step      (advance),
    .item      (s1_item),
    .target_id (target_id),
    .ctl       (ctl),
    .result    (frame_result)
  );

  bfcc_timer u_timer (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .retry_ticks (retry_ticks),
    .request     (request)
  );

  always_comb begin
    step_result              = frame_result;
    step_result.request_send = request;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign res.valid         = out_valid;
  assign res.request_send  = out_item.request_send;
  assign res.frame_matched = out_item.frame_matched;
  assign res.crc_ok        = out_item.crc_ok;
  assign res.computed_crc  = out_item.computed_crc;
  assign res.voltage_raw   = out_item.voltage_raw;
  assign res.current_raw   = out_item.current_raw;
  assign res.capacity_raw  = out_item.capacity_raw;

  // A tick can raise a request but never match a frame.
  a_request_or_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.request_send && out_item.frame_matched))
    else $error("request and frame match in one result");

  a_crc_needs_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.crc_ok) |-> out_item.frame_matched)
    else $error("CRC reported good on an unmatched frame");

endmodule
